// ===== rtl/slml_pkg.sv =====
// ----------------------------------------------------------------------------
// slml_pkg: shared types and codes of the sorted list merge linker
// Command and result codes, fixed field widths, and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package slml_pkg;

	localparam int CMD_W      = 2;
	localparam int IN_VALUE_W = 32;
	localparam int KIND_W     = 2;
	localparam int OUT_IDX_W  = 4;

	localparam int DEF_LIST_DEPTH  = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_HEAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic walk_init;
		logic step;
		logic tail;
		logic error;
	} slml_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic a_empty;
		logic b_empty;
		logic walk_end;
		logic out_free;
	} slml_sts_t;

endpackage

// ===== rtl/slml_in_if.sv =====
// ----------------------------------------------------------------------------
// slml_in_if: input item channel
// Valid/ready channel carrying one command and one value per item.
// ----------------------------------------------------------------------------
interface slml_in_if;
	import slml_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [CMD_W-1:0]             cmd;
	logic signed [IN_VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);

endinterface

// ===== rtl/slml_out_if.sv =====
// ----------------------------------------------------------------------------
// slml_out_if: result item channel
// Valid/ready channel carrying one head, link or error result per item.
// ----------------------------------------------------------------------------
interface slml_out_if;
	import slml_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic                 from_list;
	logic [OUT_IDX_W-1:0] from_index;
	logic                 to_list;
	logic [OUT_IDX_W-1:0] to_index;
	logic                 last;

	modport source (output valid, output kind, output from_list, output from_index,
		output to_list, output to_index, output last, input ready);
	modport sink (input valid, input kind, input from_list, input from_index,
		input to_list, input to_index, input last, output ready);

endinterface

// ===== rtl/slml_ram.sv =====
// ----------------------------------------------------------------------------
// slml_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slml_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/slml_dp.sv =====
// ----------------------------------------------------------------------------
// slml_dp: merge datapath
// List stores, counts, walk indices, compare and the result register.
// ----------------------------------------------------------------------------
module slml_dp #(
	parameter int LIST_DEPTH  = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  slml_pkg::slml_ctl_t                   ctl,
	output slml_pkg::slml_sts_t                   sts,
	input  logic signed [slml_pkg::IN_VALUE_W-1:0] in_value,
	slml_out_if.source                            results
);
	import slml_pkg::*;

	localparam int IDX_W = $clog2(LIST_DEPTH);
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	logic [CNT_W-1:0]            cnt_a_q, cnt_b_q, ia_q, ib_q;
	logic                        first_q, took_b_q;
	logic                        prev_list_q;
	logic [OUT_IDX_W-1:0]        prev_idx_q;
	logic                        out_valid_q;
	logic [KIND_W-1:0]           kind_q;
	logic                        from_list_q, to_list_q, last_q;
	logic [OUT_IDX_W-1:0]        from_idx_q, to_idx_q;

	logic [VALUE_WIDTH+IN_VALUE_W-1:0] value_ext;
	logic [VALUE_WIDTH-1:0]      wdata;
	logic                        we_a, we_b;
	logic [VALUE_WIDTH-1:0]      rdata_a, rdata_b;
	logic [IDX_W-1:0]            raddr_a, raddr_b;
	logic [CNT_W:0]              ia_inc, ib_inc;
	logic [CNT_W+OUT_IDX_W-1:0]  ia_ext, ib_ext;
	logic [OUT_IDX_W-1:0]        ia_out, ib_out, pick_idx;
	logic                        take_b;

	// low VALUE_WIDTH bits of the input, zero-filled above bit 31
	assign value_ext = {{VALUE_WIDTH{1'b0}}, in_value};
	assign wdata     = value_ext[VALUE_WIDTH-1:0];

	assign we_a = ctl.load_a && (cnt_a_q < CNT_W'(LIST_DEPTH));
	assign we_b = ctl.load_b && (cnt_b_q < CNT_W'(LIST_DEPTH));

	assign ia_inc = {1'b0, ia_q} + 1'b1;
	assign ib_inc = {1'b0, ib_q} + 1'b1;

	// ties go to B
	assign take_b = !($signed(rdata_a) < $signed(rdata_b));

	// address the entry that will be current in the next cycle
	always_comb begin
		raddr_a = ia_q[IDX_W-1:0];
		raddr_b = ib_q[IDX_W-1:0];
		if (ctl.walk_init) begin
			raddr_a = '0;
			raddr_b = '0;
		end else if (ctl.step) begin
			if (take_b) begin
				raddr_b = ib_inc[IDX_W-1:0];
			end else begin
				raddr_a = ia_inc[IDX_W-1:0];
			end
		end
	end

	assign ia_ext   = {{OUT_IDX_W{1'b0}}, ia_q};
	assign ib_ext   = {{OUT_IDX_W{1'b0}}, ib_q};
	assign ia_out   = ia_ext[OUT_IDX_W-1:0];
	assign ib_out   = ib_ext[OUT_IDX_W-1:0];
	assign pick_idx = take_b ? ib_out : ia_out;

	slml_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	slml_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	assign sts.a_empty  = (cnt_a_q == '0);
	assign sts.b_empty  = (cnt_b_q == '0);
	assign sts.walk_end = take_b ? (ib_inc >= {1'b0, cnt_b_q}) : (ia_inc >= {1'b0, cnt_a_q});
	assign sts.out_free = !out_valid_q || results.ready;

	// counts and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			ia_q     <= '0;
			ib_q     <= '0;
			first_q  <= 1'b0;
			took_b_q <= 1'b0;
		end else begin
			if (we_a) begin
				cnt_a_q <= cnt_a_q + 1'b1;
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (ctl.walk_init) begin
				ia_q    <= '0;
				ib_q    <= '0;
				first_q <= 1'b1;
			end else if (ctl.step) begin
				first_q  <= 1'b0;
				took_b_q <= take_b;
				if (take_b) begin
					ib_q <= ib_inc[CNT_W-1:0];
				end else begin
					ia_q <= ia_inc[CNT_W-1:0];
				end
			end
			if (ctl.tail || ctl.error) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
		end
	end

	// previous element, payload only
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			prev_list_q <= take_b;
			prev_idx_q  <= pick_idx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step || ctl.tail || ctl.error) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.error) begin
			kind_q      <= KIND_ERROR;
			from_list_q <= 1'b0;
			from_idx_q  <= '0;
			to_list_q   <= 1'b0;
			to_idx_q    <= '0;
			last_q      <= 1'b1;
		end else if (ctl.step) begin
			last_q <= 1'b0;
			if (first_q) begin
				kind_q      <= KIND_HEAD;
				from_list_q <= take_b;
				from_idx_q  <= pick_idx;
				to_list_q   <= 1'b0;
				to_idx_q    <= '0;
			end else begin
				kind_q      <= KIND_LINK;
				from_list_q <= prev_list_q;
				from_idx_q  <= prev_idx_q;
				to_list_q   <= take_b;
				to_idx_q    <= pick_idx;
			end
		end else if (ctl.tail) begin
			kind_q      <= KIND_LINK;
			from_list_q <= prev_list_q;
			from_idx_q  <= prev_idx_q;
			to_list_q   <= !took_b_q;
			to_idx_q    <= took_b_q ? ia_out : ib_out;
			last_q      <= 1'b1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kind       = kind_q;
	assign results.from_list  = from_list_q;
	assign results.from_index = from_idx_q;
	assign results.to_list    = to_list_q;
	assign results.to_index   = to_idx_q;
	assign results.last       = last_q;

endmodule

// ===== rtl/slml_ctrl.sv =====
// ----------------------------------------------------------------------------
// slml_ctrl: merge controller
// Decodes input items and sequences the empty check, the walk and the tail.
// ----------------------------------------------------------------------------
module slml_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [slml_pkg::CMD_W-1:0]   in_cmd,
	output logic                         in_ready,
	input  slml_pkg::slml_sts_t          sts,
	output slml_pkg::slml_ctl_t          ctl
);
	import slml_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_TAIL
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_LOAD_A: ctl.load_a = 1'b1;
						CMD_LOAD_B: ctl.load_b = 1'b1;
						CMD_START:  state_d = ST_START;
						default: ;
					endcase
				end
			end
			ST_START: begin
				if (sts.a_empty || sts.b_empty) begin
					if (sts.out_free) begin
						ctl.error = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					ctl.walk_init = 1'b1;
					state_d       = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.out_free) begin
					ctl.step = 1'b1;
					if (sts.walk_end) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (sts.out_free) begin
					ctl.tail = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/sorted_list_merge_linker.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge_linker: merge of two sorted linked lists
// Loads two ascending lists, then on a start item emits the merged head and
// every rewritten next-link in order, B first on equal values.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  items     in    valid/ready    cmd[1:0], value[31:0] signed
//  results   out   valid/ready    kind, from_list, from_index, to_list,
//                                 to_index, last
//
// A load item is taken while the controller is idle. A start item is accepted,
// then the counts are checked and the list RAMs primed, then the walk takes one
// step per element consumed, then the closing link is sent. The RAM read
// addresses are set ahead, so the registered read data feed the compare once per
// step. An empty list gives one error result instead. Reset clears the counts
// and the controller; the list stores hold no reset value. A stalled results
// channel holds the walk in place; items are refused until the run is done.
//
module sorted_list_merge_linker #(
	parameter int LIST_DEPTH  = slml_pkg::DEF_LIST_DEPTH,
	parameter int VALUE_WIDTH = slml_pkg::DEF_VALUE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	slml_in_if.sink    items,
	slml_out_if.source results
);
	import slml_pkg::*;

	slml_ctl_t ctl;
	slml_sts_t sts;

	// sequence loads, the empty check, the walk and the tail
	slml_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_cmd   (items.cmd),
		.in_ready (items.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// stores, compare and result register
	slml_dp #(
		.LIST_DEPTH  (LIST_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.in_value (items.value),
		.results  (results)
	);

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step || ctl.tail || ctl.error) |-> sts.out_free)
		else $error("result register loaded while occupied");

	// both counts cleared once a run ends
	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.tail || ctl.error) |=> (sts.a_empty && sts.b_empty))
		else $error("counts not cleared after a run");

	// a head is always followed by at least the closing link
	a_head_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == KIND_HEAD) |-> !results.last)
		else $error("head result marked last");

	// an error result ends the run by itself
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == KIND_ERROR) |-> results.last)
		else $error("error result not marked last");

endmodule

// ===== tb/sorted_list_merge_linker_test.sv =====
// ----------------------------------------------------------------------------
// sorted_list_merge_linker_test: self-checking bench of the list merge linker
// Loads pairs of lists, starts merges and checks each head, link and error
// result against a behavioral merge kept in a small scoreboard class, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_list_merge_linker_test;
	import slml_pkg::*;

	localparam int LIST_DEPTH       = DEF_LIST_DEPTH;
	localparam int CLK_PERIOD       = 20;
	localparam int RESET_CYCLES     = 8;
	localparam int RANDOM_ITEMS     = 380;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 100;
	localparam int LIMIT_CYCLES     = 400000;

	// cmd 3 has no meaning in the block; the bench sends it as noise
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef logic signed [IN_VALUE_W-1:0] value_t;
	typedef value_t value_q_t[$];

	// how list values are drawn
	typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES} spread_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic                 from_list;
		logic [OUT_IDX_W-1:0] from_index;
		logic                 to_list;
		logic [OUT_IDX_W-1:0] to_index;
		logic                 last;
	} merge_link_t;

	// Behavioral copy of the block: both stores, both counts, and the
	// links each start is due to produce, oldest first.
	class merge_scoreboard;
		value_t      list_a[LIST_DEPTH];
		value_t      list_b[LIST_DEPTH];
		int          count_a;
		int          count_b;
		merge_link_t links_due[$];
		int          errors;

		// Note an accepted item; return 1 when it changed the state.
		function bit note_item(logic [CMD_W-1:0] cmd, value_t value);
			int ia, ib, ci, pi;
			bit cl, pl, took_b, done, first;
			note_item = 1'b1;
			case (cmd)
				CMD_LOAD_A: begin
					if (count_a < LIST_DEPTH) begin
						list_a[count_a] = value;
						count_a++;
					end else begin
						note_item = 1'b0;
					end
				end
				CMD_LOAD_B: begin
					if (count_b < LIST_DEPTH) begin
						list_b[count_b] = value;
						count_b++;
					end else begin
						note_item = 1'b0;
					end
				end
				CMD_START: begin
					if (count_a == 0 || count_b == 0) begin
						links_due.push_back('{KIND_ERROR, 1'b0, 4'd0, 1'b0, 4'd0, 1'b1});
					end else begin
						ia = 0;
						ib = 0;
						pl = 1'b0;
						pi = 0;
						took_b = 1'b0;
						done = 1'b0;
						first = 1'b1;
						while (!done) begin
							// B wins ties
							if (list_a[ia] < list_b[ib]) begin
								cl = 1'b0;
								ci = ia;
								ia++;
								took_b = 1'b0;
								done = (ia >= count_a);
							end else begin
								cl = 1'b1;
								ci = ib;
								ib++;
								took_b = 1'b1;
								done = (ib >= count_b);
							end
							if (first)
								links_due.push_back('{KIND_HEAD, cl, ci[3:0], 1'b0, 4'd0, 1'b0});
							else
								links_due.push_back('{KIND_LINK, pl, pi[3:0], cl, ci[3:0], 1'b0});
							first = 1'b0;
							pl = cl;
							pi = ci;
						end
						// splice the exhausted list onto the other list's current head
						if (took_b)
							links_due.push_back('{KIND_LINK, pl, pi[3:0], 1'b0, ia[3:0], 1'b1});
						else
							links_due.push_back('{KIND_LINK, pl, pi[3:0], 1'b1, ib[3:0], 1'b1});
					end
					count_a = 0;
					count_b = 0;
				end
				default: begin
					note_item = 1'b0;
				end
			endcase
		endfunction

		// Check one accepted result against the oldest link due.
		function void check_result(merge_link_t got);
			merge_link_t want;
			if (links_due.size() == 0) begin
				$error("result with none due: kind %0d from %0d.%0d to %0d.%0d last %0d",
					got.kind, got.from_list, got.from_index, got.to_list, got.to_index,
					got.last);
				errors++;
				return;
			end
			want = links_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.from_list !== want.from_list) begin
				$error("from_list: expected %0d, actual %0d", want.from_list, got.from_list);
				errors++;
			end
			if (got.from_index !== want.from_index) begin
				$error("from_index: expected %0d, actual %0d", want.from_index, got.from_index);
				errors++;
			end
			if (got.to_list !== want.to_list) begin
				$error("to_list: expected %0d, actual %0d", want.to_list, got.to_list);
				errors++;
			end
			if (got.to_index !== want.to_index) begin
				$error("to_index: expected %0d, actual %0d", want.to_index, got.to_index);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return links_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	slml_in_if  items_if();
	slml_out_if results_if();

	sorted_list_merge_linker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if.sink),
		.results (results_if.source)
	);

	merge_scoreboard board;

	// Phase knobs shared by the sender and the receiver.
	bit sender_idles;
	bit recv_idles;
	bit long_hold_req;
	int fed_items;

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// Mostly short lists so that many merges fit; full stores now and then.
	function automatic int pick_len();
		if ($urandom_range(0, 7) == 0)
			return LIST_DEPTH;
		return $urandom_range(1, 8);
	endfunction

	function automatic value_t draw_value(spread_t spread);
		case (spread)
			SPREAD_WIDE:   return $urandom;
			// a narrow band gives plenty of equal values across the lists
			SPREAD_NARROW: return int'($urandom_range(0, 6)) - 3;
			default: begin
				case ($urandom_range(0, 6))
					0:       return 32'sh8000_0000;
					1:       return 32'sh8000_0001;
					2:       return -32'sd1;
					3:       return 32'sd0;
					4:       return 32'sd1;
					5:       return 32'sh7fff_fffe;
					default: return 32'sh7fff_ffff;
				endcase
			end
		endcase
	endfunction

	// Build a list of len values; keep it ascending when sorted is set.
	function automatic value_q_t make_list(int len, spread_t spread, bit sorted);
		value_q_t vals;
		value_t   v;
		int       pos;
		for (int k = 0; k < len; k++) begin
			v = draw_value(spread);
			pos = vals.size();
			if (sorted)
				while (pos > 0 && vals[pos-1] > v)
					pos--;
			vals.insert(pos, v);
		end
		return vals;
	endfunction

	// Offer one item at the current rising edge and hold it until the
	// block takes it; then note it and maybe drop valid for a gap.
	// Ready is looked at on the falling edge, where it is settled.
	task automatic send_item(logic [CMD_W-1:0] cmd, value_t value);
		int gap;
		items_if.valid <= 1'b1;
		items_if.cmd   <= cmd;
		items_if.value <= value;
		do
			@(negedge clk);
		while (!items_if.ready);
		@(posedge clk);
		if (board.note_item(cmd, value))
			fed_items++;
		gap = (sender_idles && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Load both lists with the loads of A and B interleaved at random,
	// sprinkle in an unused command now and then, and start the merge.
	task automatic run_merge(int len_a, int len_b, spread_t spread, bit sorted);
		value_q_t qa;
		value_q_t qb;
		int       ia;
		int       ib;
		qa = make_list(len_a, spread, sorted);
		qb = make_list(len_b, spread, sorted);
		ia = 0;
		ib = 0;
		while (ia < qa.size() || ib < qb.size()) begin
			if (ib >= qb.size() || (ia < qa.size() && $urandom_range(0, 1) == 1)) begin
				send_item(CMD_LOAD_A, qa[ia]);
				ia++;
			end else begin
				send_item(CMD_LOAD_B, qb[ib]);
				ib++;
			end
			if ($urandom_range(0, 15) == 0)
				send_item(CMD_UNUSED, $urandom);
		end
		send_item(CMD_START, $urandom);
	endtask

	// Result side: stall at random, or hold off for one long stretch on
	// request, and check every result the block hands over.
	initial begin
		int          stall_left;
		int          hold_left;
		bit          hold_served;
		merge_link_t got;
		stall_left = 0;
		hold_left = 0;
		hold_served = 1'b0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_served) begin
				hold_served = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				results_if.ready <= 1'b0;
				stall_left--;
			end else begin
				results_if.ready <= 1'b1;
				if (recv_idles && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			// a result seen here is taken at the next rising edge
			@(negedge clk);
			if (results_if.valid && results_if.ready) begin
				got.kind       = results_if.kind;
				got.from_list  = results_if.from_list;
				got.from_index = results_if.from_index;
				got.to_list    = results_if.to_list;
				got.to_index   = results_if.to_index;
				got.last       = results_if.last;
				board.check_result(got);
			end
		end
	end

	// Stimulus: directed corner cases, then random merges, then drain.
	initial begin
		int      base;
		int      scenario;
		int      pick;
		int      len_a;
		int      len_b;
		spread_t spread;
		bit      sorted;
		board = new;
		clk = 1'b0;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.cmd = CMD_UNUSED;
		items_if.value = '0;
		sender_idles = 1'b1;
		recv_idles = 1'b1;
		long_hold_req = 1'b0;
		fed_items = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start with both lists empty
		send_item(CMD_START, 32'sd0);
		// start with only A loaded, then with only B loaded
		send_item(CMD_LOAD_A, 32'sh8000_0000);
		send_item(CMD_START, 32'sh7fff_ffff);
		send_item(CMD_LOAD_B, 32'sh7fff_ffff);
		send_item(CMD_START, -32'sd1);
		// one element each at the far ends of the value range
		send_item(CMD_LOAD_A, 32'sh8000_0000);
		send_item(CMD_LOAD_B, 32'sh7fff_ffff);
		send_item(CMD_START, 32'sd0);
		// equal values: B goes first; an unused command in between is dropped
		send_item(CMD_LOAD_A, 32'sd5);
		send_item(CMD_UNUSED, 32'sh7fff_ffff);
		send_item(CMD_LOAD_B, 32'sd5);
		send_item(CMD_LOAD_A, 32'sd5);
		send_item(CMD_START, 32'sd0);
		// interleaved lists where A runs out first
		send_item(CMD_LOAD_A, 32'sd1);
		send_item(CMD_LOAD_B, 32'sd2);
		send_item(CMD_LOAD_A, 32'sd3);
		send_item(CMD_LOAD_B, 32'sd4);
		send_item(CMD_LOAD_B, 32'sd6);
		send_item(CMD_START, 32'sd0);

		base = fed_items;
		scenario = 0;
		while (fed_items - base < RANDOM_ITEMS) begin
			// every few merges, switch idling on or off per side
			if (scenario % 4 == 0) begin
				sender_idles = ($urandom_range(0, 3) != 0);
				recv_idles = ($urandom_range(0, 3) != 0);
			end
			spread = spread_t'($urandom_range(0, 2));
			sorted = 1'b1;
			len_a = pick_len();
			len_b = pick_len();
			pick = $urandom_range(0, 99);
			if (scenario == 5) begin
				// full stores and a stalled receiver: fill the block up
				len_a = LIST_DEPTH;
				len_b = LIST_DEPTH;
				long_hold_req = 1'b1;
			end else if (pick < 70) begin
				// ascending lists, the normal case
			end else if (pick < 80) begin
				sorted = 1'b0;
			end else if (pick < 88) begin
				if ($urandom_range(0, 1) == 1)
					len_a = 0;
				else
					len_b = 0;
			end else if (pick < 95) begin
				// loads past the store depth are dropped
				if ($urandom_range(0, 1) == 1)
					len_a = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
				else
					len_b = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
			end else begin
				len_a = 0;
				len_b = 0;
				repeat ($urandom_range(1, 3))
					send_item(CMD_UNUSED, $urandom);
			end
			run_merge(len_a, len_b, spread, sorted);
			scenario++;
		end

		items_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Stop a run that hangs.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
